/* sv/rdcc_pkg.sv */
// Shared types, constants and helpers for the response deframer with checksum check.
// No dependencies; imported by rdcc_deframe and the top level.
package rdcc_pkg;

	// Message phase
	typedef enum logic {
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	// Header byte positions
	localparam logic [2:0] HDR_OP      = 3'd0;
	localparam logic [2:0] HDR_SHIFT   = 3'd1;
	localparam logic [2:0] HDR_CSUM_HI = 3'd2;
	localparam logic [2:0] HDR_CSUM_LO = 3'd3;
	localparam logic [2:0] HDR_LEN_B3  = 3'd4;
	localparam logic [2:0] HDR_LEN_B2  = 3'd5;
	localparam logic [2:0] HDR_LEN_B1  = 3'd6;
	localparam logic [2:0] HDR_LEN_B0  = 3'd7;

	// Verdict codes
	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_BADLEN   = 2'd2;

	localparam logic [31:0] HEADER_BYTES       = 32'd8;
	localparam logic [31:0] DEFAULT_MAX_LENGTH = 32'd9000000;

	// One result beat
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic       last;
		logic [1:0] status;
		logic [7:0] op_code;
		logic [7:0] shift_amount;
	} result_t;

	// Ones'-complement 16-bit add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, acc} + {1'b0, word};
		f = {1'b0, s[15:0]} + {16'd0, s[16]};
		return f[15:0];
	endfunction

endpackage

/* sv/rdcc_in_stage.sv */
// Input register stage of the deframer: captures one byte beat per cycle while s_ready is high.
// Depends on nothing but the clock and reset; used by the top level.
module rdcc_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_valid,
	output logic       s_ready,
	input  logic [7:0] s_data,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic       valid_s1_q;
	logic [7:0] byte_s1_q;

	// Free when empty or when the held beat moves on this cycle
	assign s_ready = !valid_s1_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (s_ready) begin
			valid_s1_q <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			byte_s1_q <= s_data;
		end
	end

	assign valid_s1 = valid_s1_q;
	assign byte_s1  = byte_s1_q;

endmodule

/* sv/rdcc_deframe.sv */
// Header parser, running checksum and length checks of the deframer.
// Uses rdcc_pkg; one byte is consumed on each cycle that step is high.
module rdcc_deframe #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	output logic                res_valid,
	output rdcc_pkg::result_t   res
);
	import rdcc_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [2:0]             hdr_cnt_q, hdr_cnt_d;
	logic [7:0]             op_q, op_d;
	logic [7:0]             shift_q, shift_d;
	logic [15:0]            exp_sum_q, exp_sum_d;
	logic [31:0]            msg_len_q, msg_len_d;
	logic [LENGTH_BITS-1:0] remain_q, remain_d;
	logic [15:0]            sum_q, sum_d;
	logic [7:0]             held_q, held_d;
	logic                   held_vld_q, held_vld_d;
	logic [31:0]            max_len_q;

	logic [LENGTH_BITS-1:0] remain_dec;
	logic [31:0]            full_len;
	logic                   len_bad;
	logic [1:0]             verdict;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= DEFAULT_MAX_LENGTH;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	assign full_len   = {msg_len_q[31:8], rx_byte};
	assign len_bad    = (full_len < HEADER_BYTES) || (full_len > max_len_q) ||
	                    ((full_len >> LENGTH_BITS) != 32'd0);
	assign remain_dec = remain_q - LENGTH_BITS'(1);

	// Next state
	always_comb begin
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		op_d       = op_q;
		shift_d    = shift_q;
		exp_sum_d  = exp_sum_q;
		msg_len_d  = msg_len_q;
		remain_d   = remain_q;
		sum_d      = sum_q;
		held_d     = held_q;
		held_vld_d = held_vld_q;
		if (phase_q == PH_HEADER) begin
			hdr_cnt_d = hdr_cnt_q + 3'd1;
			case (hdr_cnt_q)
				HDR_OP: begin
					op_d       = rx_byte;
					sum_d      = 16'd0;
					held_d     = 8'd0;
					held_vld_d = 1'b0;
				end
				HDR_SHIFT: begin
					shift_d = rx_byte;
					sum_d   = oc_add(sum_q, {op_q, rx_byte});
				end
				HDR_CSUM_HI: exp_sum_d = {rx_byte, 8'd0};
				HDR_CSUM_LO: exp_sum_d = {exp_sum_q[15:8], rx_byte};
				HDR_LEN_B3:  msg_len_d = {rx_byte, 24'd0};
				HDR_LEN_B2: begin
					msg_len_d = {msg_len_q[31:24], rx_byte, 16'd0};
					sum_d     = oc_add(sum_q, {msg_len_q[31:24], rx_byte});
				end
				HDR_LEN_B1: msg_len_d = {msg_len_q[31:16], rx_byte, 8'd0};
				HDR_LEN_B0: begin
					msg_len_d = full_len;
					sum_d     = oc_add(sum_q, {msg_len_q[15:8], rx_byte});
					if (!len_bad && (full_len != HEADER_BYTES)) begin
						remain_d = full_len[LENGTH_BITS-1:0] - LENGTH_BITS'(HEADER_BYTES);
						phase_d  = PH_PAYLOAD;
					end
				end
				default: ;
			endcase
		end else begin
			remain_d = remain_dec;
			if (held_vld_q) begin
				sum_d      = oc_add(sum_q, {held_q, rx_byte});
				held_d     = 8'd0;
				held_vld_d = 1'b0;
			end else if (remain_dec == '0) begin
				// odd last byte counts as a high byte
				sum_d = oc_add(sum_q, {rx_byte, 8'd0});
			end else begin
				held_d     = rx_byte;
				held_vld_d = 1'b1;
			end
			if (remain_dec == '0) begin
				phase_d   = PH_HEADER;
				hdr_cnt_d = HDR_OP;
			end
		end
	end

	assign verdict = (~sum_d == exp_sum_q) ? ST_GOOD : ST_MISMATCH;

	// Result beat
	always_comb begin
		res_valid          = 1'b0;
		res.payload_byte   = 8'd0;
		res.byte_valid     = 1'b0;
		res.last           = 1'b0;
		res.status         = ST_GOOD;
		res.op_code        = op_q;
		res.shift_amount   = shift_q;
		if (phase_q == PH_HEADER) begin
			if (hdr_cnt_q == HDR_LEN_B0) begin
				if (len_bad) begin
					res_valid  = 1'b1;
					res.last   = 1'b1;
					res.status = ST_BADLEN;
				end else if (full_len == HEADER_BYTES) begin
					res_valid  = 1'b1;
					res.last   = 1'b1;
					res.status = verdict;
				end
			end
		end else begin
			res_valid        = 1'b1;
			res.payload_byte = rx_byte;
			res.byte_valid   = 1'b1;
			if (remain_dec == '0) begin
				res.last   = 1'b1;
				res.status = verdict;
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= HDR_OP;
			op_q       <= 8'd0;
			shift_q    <= 8'd0;
			exp_sum_q  <= 16'd0;
			msg_len_q  <= 32'd0;
			remain_q   <= '0;
			sum_q      <= 16'd0;
			held_q     <= 8'd0;
			held_vld_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			hdr_cnt_q  <= hdr_cnt_d;
			op_q       <= op_d;
			shift_q    <= shift_d;
			exp_sum_q  <= exp_sum_d;
			msg_len_q  <= msg_len_d;
			remain_q   <= remain_d;
			sum_q      <= sum_d;
			held_q     <= held_d;
			held_vld_q <= held_vld_d;
		end
	end

endmodule

/* sv/response_deframer_checksum_check_core.sv */
// Top level of the response deframer with checksum check.
// Depends on rdcc_pkg, rdcc_in_stage and rdcc_deframe.
//
// Usage:
//   s_axis carries the received message one byte per beat. The first eight
//   bytes are the header (op, shift, checksum, big-endian total length);
//   payload bytes follow. m_axis gives one beat per payload byte, and one
//   verdict beat right after the header when the payload is empty or the
//   length is rejected. tlast marks the beat that ends a message and carries
//   the status in tuser.
//   Path: a byte accepted into the input register moves on, if it makes a
//   result, to the output register and shows on m_axis (two register stages).
//   Throughput: one byte per cycle unless stalled; the checksum add and
//   the length counter each settle within the single processing stage.
//   Stall: while m_axis_tready is low and a result is held, the input
//   register still takes one more byte; s_axis_tready then drops until the
//   held result is taken. Header bytes wait for the output slot as well.
//   Reset: arst_n clears all state; the limit returns to 9000000 and the
//   next byte is taken as the first header byte.
//   cfg_wr_en / cfg_wr_data write the length limit; write only while idle.
module response_deframer_checksum_check_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] op_code,
	                                    // [23:16] shift_amount
	output logic        m_axis_tlast,   // last
	output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [2:1] status
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import rdcc_pkg::*;

	logic    valid_s1;
	logic [7:0] byte_s1;
	logic    advance;
	logic    res_valid;
	result_t res;
	logic    out_vld_q;
	result_t out_q;

	// Stage 1 moves on when the output register is free or being drained
	assign advance = valid_s1 && (!out_vld_q || m_axis_tready);

	rdcc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.s_data   (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	rdcc_deframe #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_deframe (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q.shift_amount, out_q.op_code, out_q.payload_byte};
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tuser  = {out_q.status, out_q.byte_valid};

endmodule
